/* rtl/line_segment_intersection_unit_defines.svh */
// assertion macros shared by the segment intersection rtl
`ifndef LINE_SEGMENT_INTERSECTION_UNIT_DEFINES_SVH
`define LINE_SEGMENT_INTERSECTION_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define LSI_ASSERT_IMPL(label, clk_s, rstn_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("lsi assertion failed");

// next-cycle implication, disabled during reset
`define LSI_ASSERT_NEXT(label, clk_s, rstn_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error("lsi assertion failed");

`endif

/* rtl/lsi_pkg.sv */
// shared types and constants for the segment intersection pipeline
package lsi_pkg;

    localparam int COORD_W     = 32;
    localparam int SLOPE_FRAC  = 32;
    localparam int SLOPE_W     = 64;
    localparam int REM_W       = 65;
    localparam int NQ_W        = 64;
    localparam int SLOPE_STEPS = 64;
    localparam int X_STEPS     = 34;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [SLOPE_W-1:0] slope_t;
    typedef logic [REM_W-1:0] rem_t;
    typedef logic [NQ_W-1:0] nq_t;

    typedef struct packed {
        coord_t sx;
        coord_t sy;
        coord_t ex;
        coord_t ey;
        logic   vert;
        logic   neg;
    } seg_t;

    typedef enum logic [1:0] {
        MODE_MISS = 2'b00,
        MODE_VERT = 2'b01,
        MODE_GEN  = 2'b10
    } mode_t;

    typedef struct packed {
        mode_t  mode;
        coord_t xv;
        coord_t vy_lo;
        coord_t vy_hi;
        coord_t s_y0;
        coord_t s_x0;
        slope_t s_m;
        coord_t a_sx;
        coord_t a_ex;
        coord_t b_sx;
        coord_t b_ex;
    } ctx_t;

    typedef struct packed {
        logic   valid;
        seg_t   a;
        seg_t   b;
        slope_t m_a;
        slope_t m_b;
    } slope_word_t;

    typedef struct packed {
        logic   valid;
        logic   hit;
        coord_t x;
        coord_t y;
    } result_t;

endpackage

/* rtl/lsi_div_cell.sv */
// one restoring division step: shifts in a numerator bit, emits one quotient bit
module lsi_div_cell (
    input  logic          clk,
    input  logic          en,
    input  lsi_pkg::rem_t rem_in,
    input  lsi_pkg::nq_t  nq_in,
    input  lsi_pkg::rem_t den_in,
    output lsi_pkg::rem_t rem_out,
    output lsi_pkg::nq_t  nq_out,
    output lsi_pkg::rem_t den_out
);
    import lsi_pkg::*;

    logic [REM_W:0] trial;
    logic [REM_W:0] diff;
    logic           take;
    rem_t           rem_reg;
    rem_t           rem_next;
    nq_t            nq_reg;
    nq_t            nq_next;
    rem_t           den_reg;

    always_comb
    begin
        trial    = {rem_in, nq_in[NQ_W-1]};
        diff     = trial - {1'b0, den_in};
        take     = !diff[REM_W];
        rem_next = take ? diff[REM_W-1:0] : trial[REM_W-1:0];
        // numerator bits leave at the top, quotient bits enter at the bottom
        nq_next  = {nq_in[NQ_W-2:0], take};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            nq_reg  <= nq_next;
            den_reg <= den_in;
        end
    end

    assign rem_out = rem_reg;
    assign nq_out  = nq_reg;
    assign den_out = den_reg;

endmodule

/* rtl/lsi_front.sv */
// endpoint ordering and per-segment slope division chains
module lsi_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_fire,
    input  lsi_pkg::coord_t      a_start_x,
    input  lsi_pkg::coord_t      a_start_y,
    input  lsi_pkg::coord_t      a_end_x,
    input  lsi_pkg::coord_t      a_end_y,
    input  lsi_pkg::coord_t      b_start_x,
    input  lsi_pkg::coord_t      b_start_y,
    input  lsi_pkg::coord_t      b_end_x,
    input  lsi_pkg::coord_t      b_end_y,
    output lsi_pkg::slope_word_t slope_word
);
    import lsi_pkg::*;

    localparam int DEPTH = SLOPE_STEPS + 2;
    localparam slope_t SLOPE_MAX = {1'b0, {(SLOPE_W-1){1'b1}}};
    localparam slope_t SLOPE_MIN = {1'b1, {(SLOPE_W-1){1'b0}}};

    function automatic seg_t order_seg(coord_t x0, coord_t y0, coord_t x1, coord_t y1);
        seg_t s;
        if (x0 > x1)
        begin
            s.sx = x1;
            s.sy = y1;
            s.ex = x0;
            s.ey = y0;
        end
        else
        begin
            s.sx = x0;
            s.sy = y0;
            s.ex = x1;
            s.ey = y1;
        end
        s.vert = (s.sx == s.ex);
        s.neg  = (s.ey < s.sy);
        return s;
    endfunction

    function automatic slope_t sat_slope(nq_t mag, logic neg);
        slope_t m;
        if (neg)
            m = mag[NQ_W-1] ? SLOPE_MIN : $signed(nq_t'(0) - mag);
        else
            m = mag[NQ_W-1] ? SLOPE_MAX : $signed(mag);
        return m;
    endfunction

    logic [DEPTH-1:0]     vld_reg;
    seg_t                 seg_a_reg [DEPTH];
    seg_t                 seg_b_reg [DEPTH];
    slope_t               m_a_reg;
    slope_t               m_b_reg;
    slope_t               m_a_next;
    slope_t               m_b_next;
    logic [COORD_W-1:0]   dx_a;
    logic [COORD_W-1:0]   dx_b;
    logic [COORD_W-1:0]   dy_a;
    logic [COORD_W-1:0]   dy_b;
    nq_t                  nq0_a;
    nq_t                  nq0_b;
    rem_t                 den0_a;
    rem_t                 den0_b;
    rem_t                 rem_a [SLOPE_STEPS];
    nq_t                  nq_a  [SLOPE_STEPS];
    rem_t                 den_a [SLOPE_STEPS];
    rem_t                 rem_b [SLOPE_STEPS];
    nq_t                  nq_b  [SLOPE_STEPS];
    rem_t                 den_b [SLOPE_STEPS];

    always_comb
    begin
        dx_a   = seg_a_reg[0].ex - seg_a_reg[0].sx;
        dx_b   = seg_b_reg[0].ex - seg_b_reg[0].sx;
        dy_a   = seg_a_reg[0].neg ? seg_a_reg[0].sy - seg_a_reg[0].ey
                                  : seg_a_reg[0].ey - seg_a_reg[0].sy;
        dy_b   = seg_b_reg[0].neg ? seg_b_reg[0].sy - seg_b_reg[0].ey
                                  : seg_b_reg[0].ey - seg_b_reg[0].sy;
        nq0_a  = {dy_a, {SLOPE_FRAC{1'b0}}};
        nq0_b  = {dy_b, {SLOPE_FRAC{1'b0}}};
        den0_a = {{(REM_W-COORD_W){1'b0}}, dx_a};
        den0_b = {{(REM_W-COORD_W){1'b0}}, dx_b};
        m_a_next = sat_slope(nq_a[SLOPE_STEPS-1], seg_a_reg[SLOPE_STEPS].neg);
        m_b_next = sat_slope(nq_b[SLOPE_STEPS-1], seg_b_reg[SLOPE_STEPS].neg);
    end

    for (genvar j = 0; j < SLOPE_STEPS; j++)
    begin : g_cell
        if (j == 0)
        begin : g_head
            lsi_div_cell u_cell_a (
                .clk     (clk),
                .en      (en),
                .rem_in  ('0),
                .nq_in   (nq0_a),
                .den_in  (den0_a),
                .rem_out (rem_a[j]),
                .nq_out  (nq_a[j]),
                .den_out (den_a[j])
            );
            lsi_div_cell u_cell_b (
                .clk     (clk),
                .en      (en),
                .rem_in  ('0),
                .nq_in   (nq0_b),
                .den_in  (den0_b),
                .rem_out (rem_b[j]),
                .nq_out  (nq_b[j]),
                .den_out (den_b[j])
            );
        end
        else
        begin : g_link
            lsi_div_cell u_cell_a (
                .clk     (clk),
                .en      (en),
                .rem_in  (rem_a[j-1]),
                .nq_in   (nq_a[j-1]),
                .den_in  (den_a[j-1]),
                .rem_out (rem_a[j]),
                .nq_out  (nq_a[j]),
                .den_out (den_a[j])
            );
            lsi_div_cell u_cell_b (
                .clk     (clk),
                .en      (en),
                .rem_in  (rem_b[j-1]),
                .nq_in   (nq_b[j-1]),
                .den_in  (den_b[j-1]),
                .rem_out (rem_b[j]),
                .nq_out  (nq_b[j]),
                .den_out (den_b[j])
            );
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[DEPTH-2:0], in_fire};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            seg_a_reg[0] <= order_seg(a_start_x, a_start_y, a_end_x, a_end_y);
            seg_b_reg[0] <= order_seg(b_start_x, b_start_y, b_end_x, b_end_y);
            for (int k = 1; k < DEPTH; k++)
            begin
                seg_a_reg[k] <= seg_a_reg[k-1];
                seg_b_reg[k] <= seg_b_reg[k-1];
            end
            m_a_reg <= m_a_next;
            m_b_reg <= m_b_next;
        end
    end

    assign slope_word.valid = vld_reg[DEPTH-1];
    assign slope_word.a     = seg_a_reg[DEPTH-1];
    assign slope_word.b     = seg_b_reg[DEPTH-1];
    assign slope_word.m_a   = m_a_reg;
    assign slope_word.m_b   = m_b_reg;

endmodule

/* rtl/lsi_solve.sv */
// case selection, crossing x division chain and crossing y evaluation
module lsi_solve (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  lsi_pkg::slope_word_t slope_word,
    output lsi_pkg::result_t     res
);
    import lsi_pkg::*;
    `include "line_segment_intersection_unit_defines.svh"

    localparam int K_DIV = 4;
    localparam int K_D1  = K_DIV + X_STEPS + 1;
    localparam int K_D2  = K_D1 + 1;
    localparam int K_F1  = K_D2 + 1;
    localparam int K_F2  = K_F1 + 1;
    localparam int K_F3  = K_F2 + 1;
    localparam int K_F4  = K_F3 + 1;
    localparam int DEPTH = K_F4 + 1;
    localparam int NUM_W = 98;
    localparam int MAG_W = NUM_W - 1;
    localparam int X_W   = X_STEPS + 1;
    localparam int YQ_W  = NUM_W - SLOPE_FRAC;

    logic [DEPTH-1:0]           vld_reg;
    ctx_t                       ctx_reg [DEPTH];
    ctx_t                       ctx_next;
    seg_t                       sa;
    seg_t                       sb;
    seg_t                       sv;
    seg_t                       so;
    logic                       meq;
    logic                       span_v;

    // product and difference stages
    logic signed [SLOPE_W:0]    pl_a_reg;
    logic signed [SLOPE_W:0]    pl_b_reg;
    logic signed [SLOPE_W-1:0]  ph_a_reg;
    logic signed [SLOPE_W-1:0]  ph_b_reg;
    logic signed [SLOPE_W:0]    den_reg [K_DIV-1];
    logic signed [COORD_W:0]    dy0_reg [2];
    logic signed [95:0]         p_a_reg;
    logic signed [95:0]         p_b_reg;
    logic signed [NUM_W-1:0]    num_reg;
    logic [NUM_W-1:0]           num_abs;
    logic [MAG_W-1:0]           num_mag_reg;
    rem_t                       den_mag_reg;
    rem_t                       den_abs;
    logic                       qneg_c4_reg;
    rem_t                       rem0_reg;
    nq_t                        nq0_reg;
    rem_t                       den0_reg;
    logic [K_D1:K_DIV]          big_reg;
    logic [K_D1-1:K_DIV]        qneg_reg;

    rem_t                       rem_x [X_STEPS];
    nq_t                        nq_x  [X_STEPS];
    rem_t                       den_x [X_STEPS];

    logic [X_STEPS-1:0]         q_mag;
    logic signed [X_W-1:0]      x_reg;
    logic signed [X_W-1:0]      x_next;
    logic                       gen_hit;
    logic [K_F4:K_D2]           hitp_reg;
    logic                       hitp_next;
    coord_t                     xsel_reg [K_D2:K_F4];
    coord_t                     xsel_next;
    ctx_t                       cd;
    logic [COORD_W-1:0]         d_reg;
    logic [SLOPE_W-1:0]         ml_reg;
    logic signed [SLOPE_W:0]    mh_reg;
    logic signed [NUM_W-1:0]    v_reg;
    logic [NUM_W-1:0]           v_round;
    logic signed [YQ_W-1:0]     yq_reg;
    ctx_t                       cf;
    logic                       in_y;
    logic                       y_fits;
    coord_t                     y_sat;

    // case selection and context for the later stages
    always_comb
    begin
        sa  = slope_word.a;
        sb  = slope_word.b;
        meq = (slope_word.m_a == slope_word.m_b);
        sv  = sa.vert ? sa : sb;
        so  = sa.vert ? sb : sa;
        span_v = (sv.sx >= so.sx) && (sv.sx <= so.ex);
        ctx_next = '0;
        priority if (sa.vert && sb.vert)
            ctx_next.mode = MODE_MISS;
        else if (sa.vert || sb.vert)
            ctx_next.mode = span_v ? MODE_VERT : MODE_MISS;
        else if (meq)
            ctx_next.mode = MODE_MISS;
        else
            ctx_next.mode = MODE_GEN;
        ctx_next.xv    = sv.sx;
        ctx_next.vy_lo = (sv.sy < sv.ey) ? sv.sy : sv.ey;
        ctx_next.vy_hi = (sv.sy < sv.ey) ? sv.ey : sv.sy;
        // y is always evaluated on the other segment, or on segment a
        ctx_next.s_y0  = sa.vert ? sb.sy : sa.sy;
        ctx_next.s_x0  = sa.vert ? sb.sx : sa.sx;
        ctx_next.s_m   = sa.vert ? slope_word.m_b : slope_word.m_a;
        ctx_next.a_sx  = sa.sx;
        ctx_next.a_ex  = sa.ex;
        ctx_next.b_sx  = sb.sx;
        ctx_next.b_ex  = sb.ex;
    end

    always_comb
    begin
        num_abs = num_reg[NUM_W-1] ? NUM_W'(-num_reg) : NUM_W'(num_reg);
        den_abs = den_reg[K_DIV-2][SLOPE_W] ? rem_t'(-den_reg[K_DIV-2])
                                            : rem_t'(den_reg[K_DIV-2]);
    end

    for (genvar j = 0; j < X_STEPS; j++)
    begin : g_cell
        if (j == 0)
        begin : g_head
            lsi_div_cell u_cell (
                .clk     (clk),
                .en      (en),
                .rem_in  (rem0_reg),
                .nq_in   (nq0_reg),
                .den_in  (den0_reg),
                .rem_out (rem_x[j]),
                .nq_out  (nq_x[j]),
                .den_out (den_x[j])
            );
        end
        else
        begin : g_link
            lsi_div_cell u_cell (
                .clk     (clk),
                .en      (en),
                .rem_in  (rem_x[j-1]),
                .nq_in   (nq_x[j-1]),
                .den_in  (den_x[j-1]),
                .rem_out (rem_x[j]),
                .nq_out  (nq_x[j]),
                .den_out (den_x[j])
            );
        end
    end

    always_comb
    begin
        q_mag  = nq_x[X_STEPS-1][X_STEPS-1:0];
        x_next = qneg_reg[K_D1-1] ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
        cd     = ctx_reg[K_D1];
        gen_hit = !big_reg[K_D1]
            && (x_reg >= $signed({cd.a_sx[COORD_W-1], cd.a_sx}))
            && (x_reg <= $signed({cd.a_ex[COORD_W-1], cd.a_ex}))
            && (x_reg >= $signed({cd.b_sx[COORD_W-1], cd.b_sx}))
            && (x_reg <= $signed({cd.b_ex[COORD_W-1], cd.b_ex}));
        hitp_next = (cd.mode == MODE_VERT) || ((cd.mode == MODE_GEN) && gen_hit);
        xsel_next = (cd.mode == MODE_VERT) ? cd.xv : coord_t'(x_reg[COORD_W-1:0]);
        // truncate toward zero on the way down by 2^32
        v_round = v_reg + {{(NUM_W-SLOPE_FRAC){1'b0}}, {SLOPE_FRAC{v_reg[NUM_W-1]}}};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[DEPTH-2:0], slope_word.valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctx_reg[0] <= ctx_next;
            for (int k = 1; k < DEPTH; k++)
                ctx_reg[k] <= ctx_reg[k-1];

            // partial products of m * x_start
            pl_a_reg   <= $signed({1'b0, slope_word.m_a[SLOPE_FRAC-1:0]}) * sa.sx;
            ph_a_reg   <= $signed(slope_word.m_a[SLOPE_W-1:SLOPE_FRAC]) * sa.sx;
            pl_b_reg   <= $signed({1'b0, slope_word.m_b[SLOPE_FRAC-1:0]}) * sb.sx;
            ph_b_reg   <= $signed(slope_word.m_b[SLOPE_W-1:SLOPE_FRAC]) * sb.sx;
            den_reg[0] <= $signed({slope_word.m_a[SLOPE_W-1], slope_word.m_a})
                        - $signed({slope_word.m_b[SLOPE_W-1], slope_word.m_b});
            dy0_reg[0] <= $signed({sb.sy[COORD_W-1], sb.sy})
                        - $signed({sa.sy[COORD_W-1], sa.sy});

            p_a_reg    <= $signed({ph_a_reg, {SLOPE_FRAC{1'b0}}})
                        + $signed({{(96-SLOPE_W-1){pl_a_reg[SLOPE_W]}}, pl_a_reg});
            p_b_reg    <= $signed({ph_b_reg, {SLOPE_FRAC{1'b0}}})
                        + $signed({{(96-SLOPE_W-1){pl_b_reg[SLOPE_W]}}, pl_b_reg});
            den_reg[1] <= den_reg[0];
            dy0_reg[1] <= dy0_reg[0];

            num_reg    <= $signed({{(COORD_W+1){dy0_reg[1][COORD_W]}}, dy0_reg[1],
                                   {SLOPE_FRAC{1'b0}}})
                        - $signed({{2{p_b_reg[95]}}, p_b_reg})
                        + $signed({{2{p_a_reg[95]}}, p_a_reg});
            den_reg[2] <= den_reg[1];

            num_mag_reg <= num_abs[MAG_W-1:0];
            den_mag_reg <= den_abs;
            qneg_c4_reg <= num_reg[NUM_W-1] ^ den_reg[K_DIV-2][SLOPE_W];

            // a quotient of 2^34 or more is far outside any span
            big_reg[K_DIV]  <= {2'b00, num_mag_reg} >= {den_mag_reg, {X_STEPS{1'b0}}};
            qneg_reg[K_DIV] <= qneg_c4_reg;
            rem0_reg <= {{(REM_W-(MAG_W-X_STEPS)){1'b0}}, num_mag_reg[MAG_W-1:X_STEPS]};
            nq0_reg  <= {num_mag_reg[X_STEPS-1:0], {(NQ_W-X_STEPS){1'b0}}};
            den0_reg <= den_mag_reg;
            big_reg[K_D1:K_DIV+1]    <= big_reg[K_D1-1:K_DIV];
            qneg_reg[K_D1-1:K_DIV+1] <= qneg_reg[K_D1-2:K_DIV];

            x_reg <= x_next;

            hitp_reg[K_D2] <= hitp_next;
            xsel_reg[K_D2] <= xsel_next;
            hitp_reg[K_F4:K_D2+1] <= hitp_reg[K_F4-1:K_D2];
            for (int k = K_D2 + 1; k <= K_F4; k++)
                xsel_reg[k] <= xsel_reg[k-1];

            d_reg  <= xsel_reg[K_D2] - ctx_reg[K_D2].s_x0;
            ml_reg <= SLOPE_W'(ctx_reg[K_F1].s_m[SLOPE_FRAC-1:0] * d_reg);
            mh_reg <= $signed(ctx_reg[K_F1].s_m[SLOPE_W-1:SLOPE_FRAC]) * $signed({1'b0, d_reg});
            v_reg  <= $signed({{(NUM_W-SLOPE_W){ctx_reg[K_F2].s_y0[COORD_W-1]}},
                               ctx_reg[K_F2].s_y0, {SLOPE_FRAC{1'b0}}})
                    + $signed({mh_reg[SLOPE_W], mh_reg, {SLOPE_FRAC{1'b0}}})
                    + $signed({{(NUM_W-SLOPE_W){1'b0}}, ml_reg});
            yq_reg <= $signed(v_round[NUM_W-1:SLOPE_FRAC]);
        end
    end

    always_comb
    begin
        cf     = ctx_reg[K_F4];
        in_y   = (yq_reg >= $signed({{(YQ_W-COORD_W){cf.vy_lo[COORD_W-1]}}, cf.vy_lo}))
              && (yq_reg <= $signed({{(YQ_W-COORD_W){cf.vy_hi[COORD_W-1]}}, cf.vy_hi}));
        y_fits = (&yq_reg[YQ_W-1:COORD_W-1]) || !(|yq_reg[YQ_W-1:COORD_W-1]);
        if (y_fits)
            y_sat = coord_t'(yq_reg[COORD_W-1:0]);
        else if (yq_reg[YQ_W-1])
            y_sat = {1'b1, {(COORD_W-1){1'b0}}};
        else
            y_sat = {1'b0, {(COORD_W-1){1'b1}}};

        res.valid = vld_reg[K_F4];
        res.hit   = 1'b0;
        res.x     = '0;
        res.y     = '0;
        unique case (cf.mode)
            MODE_VERT:
            begin
                res.hit = hitp_reg[K_F4] && in_y;
                res.y   = coord_t'(yq_reg[COORD_W-1:0]);
            end
            MODE_GEN:
            begin
                res.hit = hitp_reg[K_F4];
                res.y   = y_sat;
            end
            default:
            begin
                res.hit = 1'b0;
            end
        endcase
        if (res.hit)
            res.x = xsel_reg[K_F4];
        else
            res.y = '0;
    end

    `LSI_ASSERT_IMPL(a_gen_in_span, clk, rst_n,
        res.valid && res.hit && cf.mode == MODE_GEN,
        res.x >= cf.a_sx && res.x <= cf.a_ex && res.x >= cf.b_sx && res.x <= cf.b_ex)
    `LSI_ASSERT_IMPL(a_vert_x, clk, rst_n,
        res.valid && res.hit && cf.mode == MODE_VERT, res.x == cf.xv)
    `LSI_ASSERT_IMPL(a_miss_mode, clk, rst_n,
        res.valid && cf.mode == MODE_MISS, !res.hit)

endmodule

/* rtl/line_segment_intersection_unit.sv */
// 2d segment intersection, top level with handshake and output register
//
// input channel: in_valid / in_ready carry one word of two segments, each as
// start and end points in signed q20.12. output channel: out_valid / out_ready
// carry hit and the crossing point (cross_x, cross_y), both zero on a miss.
// one word is taken per clock while the pipeline is not held; each result passes through
// the 64-cell slope divider chains, the 34-cell crossing divider chain and the
// product and rounding stages around them. every stage advances together; when
// out_valid is high and out_ready is low the whole pipeline holds and in_ready
// drops until the result is taken, so nothing is lost or repeated. reset clears
// all valid bits and out_valid; data registers, the output hit and crossing point
// among them, are not reset. there are no registers to program.
module line_segment_intersection_unit (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  lsi_pkg::coord_t a_start_x,
    input  lsi_pkg::coord_t a_start_y,
    input  lsi_pkg::coord_t a_end_x,
    input  lsi_pkg::coord_t a_end_y,
    input  lsi_pkg::coord_t b_start_x,
    input  lsi_pkg::coord_t b_start_y,
    input  lsi_pkg::coord_t b_end_x,
    input  lsi_pkg::coord_t b_end_y,
    output logic            out_valid,
    input  logic            out_ready,
    output logic            hit,
    output lsi_pkg::coord_t cross_x,
    output lsi_pkg::coord_t cross_y
);
    import lsi_pkg::*;
    `include "line_segment_intersection_unit_defines.svh"

    logic        en;
    logic        in_fire;
    slope_word_t slope_word;
    result_t     res;
    logic        out_valid_reg;
    logic        hit_reg;
    coord_t      cross_x_reg;
    coord_t      cross_y_reg;

    // pipeline moves unless a finished word is stuck at the output
    assign en      = !out_valid_reg || out_ready;
    assign in_fire = in_valid && en;

    lsi_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_fire    (in_fire),
        .a_start_x  (a_start_x),
        .a_start_y  (a_start_y),
        .a_end_x    (a_end_x),
        .a_end_y    (a_end_y),
        .b_start_x  (b_start_x),
        .b_start_y  (b_start_y),
        .b_end_x    (b_end_x),
        .b_end_y    (b_end_y),
        .slope_word (slope_word)
    );

    lsi_solve u_solve (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .slope_word (slope_word),
        .res        (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= res.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_reg     <= res.hit;
            cross_x_reg <= res.x;
            cross_y_reg <= res.y;
        end
    end

    assign in_ready  = en;
    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;
    assign cross_x   = cross_x_reg;
    assign cross_y   = cross_y_reg;

    `LSI_ASSERT_IMPL(a_miss_zero, clk, rst_n, out_valid && !hit, cross_x == '0 && cross_y == '0)
    `LSI_ASSERT_IMPL(a_stall_full, clk, rst_n, !in_ready, out_valid && !out_ready)
    `LSI_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(hit) && $stable(cross_x) && $stable(cross_y))

endmodule
